// ----- hdl/lexer_input_buffer_assert.svh -----
// Assertion macros used by the lexer input buffer checker.
`ifndef LEXER_INPUT_BUFFER_ASSERT_SVH
`define LEXER_INPUT_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define LXB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer input buffer check failed");

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define LXB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer input buffer check failed");

`endif

// ----- hdl/lxb_pkg.sv -----
// Package with types, codes and constants of the lexer input buffer.
package lxb_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int HIST_BINS_DEF   = 128;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OP_W     = 4;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 10;
  localparam int CAP_W    = 11;
  localparam int HCOUNT_W = 16;
  localparam int GM_W     = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int CAP_RESET  = 256;
  localparam int STEP_RESET = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_GET     = 4'd1,
    OP_RETRACT = 4'd2,
    OP_SETMARK = 4'd3,
    OP_RESTORE = 4'd4,
    OP_RECOVER = 4'd5,
    OP_CLEAR   = 4'd6,
    OP_READAT  = 4'd7,
    OP_HIST    = 4'd8
  } op_e;

  typedef enum logic [GM_W-1:0] {
    GM_FIXED = 2'd0,
    GM_ADD   = 2'd1,
    GM_MUL   = 2'd2
  } gm_e;

  typedef enum logic [1:0] {
    REG_INIT_CAP = 2'd0,
    REG_STEP     = 2'd1,
    REG_MODE     = 2'd2,
    REG_TERM     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CAP_W-1:0]  init_cap;
    logic [CAP_W-1:0]  growth_step;
    gm_e               growth_mode;
    logic [CHAR_W-1:0] term;
  } cfg_t;

endpackage

// ----- hdl/lxb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lxb_ram #(
  parameter int WIDTH = lxb_pkg::CHAR_W,
  parameter int DEPTH = lxb_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lxb_regs.sv -----
// APB configuration registers of the lexer input buffer.
module lxb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lxb_pkg::ADDR_W-1:0]  paddr,
  input  logic [lxb_pkg::DATA_W-1:0]  pwdata,
  output logic [lxb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lxb_pkg::cfg_t               cfg_o
);

  lxb_pkg::cfg_t    cfg_q;
  lxb_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = lxb_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_cap    <= lxb_pkg::CAP_W'(lxb_pkg::CAP_RESET);
      cfg_q.growth_step <= lxb_pkg::CAP_W'(lxb_pkg::STEP_RESET);
      cfg_q.growth_mode <= lxb_pkg::GM_FIXED;
      cfg_q.term        <= '0;
    end else if (wr_en) begin
      unique case (idx)
        lxb_pkg::REG_INIT_CAP: cfg_q.init_cap    <= pwdata[lxb_pkg::CAP_W-1:0];
        lxb_pkg::REG_STEP:     cfg_q.growth_step <= pwdata[lxb_pkg::CAP_W-1:0];
        lxb_pkg::REG_MODE:     cfg_q.growth_mode <= lxb_pkg::gm_e'(pwdata[lxb_pkg::GM_W-1:0]);
        lxb_pkg::REG_TERM:     cfg_q.term        <= pwdata[lxb_pkg::CHAR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lxb_pkg::REG_INIT_CAP: prdata = lxb_pkg::DATA_W'(cfg_q.init_cap);
      lxb_pkg::REG_STEP:     prdata = lxb_pkg::DATA_W'(cfg_q.growth_step);
      lxb_pkg::REG_MODE:     prdata = lxb_pkg::DATA_W'(cfg_q.growth_mode);
      lxb_pkg::REG_TERM:     prdata = lxb_pkg::DATA_W'(cfg_q.term);
    endcase
  end

endmodule

// ----- hdl/lxb_core.sv -----
// Operation sequencer with the byte store and histogram memories.
module lxb_core #(
  parameter int STORE_DEPTH = lxb_pkg::STORE_DEPTH_DEF,
  parameter int HIST_BINS   = lxb_pkg::HIST_BINS_DEF,
  parameter int COUNT_WIDTH = lxb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lxb_pkg::cfg_t                 cfg_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [lxb_pkg::OP_W-1:0]      operation_i,
  input  logic [lxb_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [lxb_pkg::POS_W-1:0]     position_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [lxb_pkg::CHAR_W-1:0]    char_out_o,
  output logic [lxb_pkg::HCOUNT_W-1:0]  hist_count_o,
  output logic [lxb_pkg::CAP_W-1:0]     write_pos_o,
  output logic [lxb_pkg::CAP_W-1:0]     read_pos_o,
  output logic [lxb_pkg::POS_W-1:0]     mark_pos_o,
  output logic [lxb_pkg::CAP_W-1:0]     capacity_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          was_grown_o,
  output logic [lxb_pkg::CHAR_W-1:0]    byte_sum_o
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int PW  = $clog2(STORE_DEPTH + 1);
  localparam int HBW = $clog2(HIST_BINS);
  localparam int GW  = PW + lxb_pkg::CAP_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);
  localparam logic [PW-1:0] CAP_RST =
    PW'((lxb_pkg::CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : lxb_pkg::CAP_RESET);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } st_e;

  st_e                          state_q, state_d;
  lxb_pkg::op_e                 op_q;
  logic [lxb_pkg::CHAR_W-1:0]   ch_q;
  logic [lxb_pkg::POS_W-1:0]    pos_q;
  logic [PW-1:0]                wi_q, wi_d, rd_q, rd_d, cap_q, cap_d;
  logic [lxb_pkg::POS_W-1:0]    mark_q, mark_d;
  logic                         empty_q, empty_d, full_q, full_d, grown_q, grown_d;
  logic [lxb_pkg::CHAR_W-1:0]   sum_q, sum_d;
  logic [HIST_BINS-1:0]         hvalid_q;
  logic                         done_q;
  logic                         ok_q, ok_d;
  logic [lxb_pkg::CHAR_W-1:0]   cout_q, cout_d;
  logic [lxb_pkg::HCOUNT_W-1:0] hcnt_q, hcnt_d;
  logic                         accept;
  logic [PW-1:0]                wi_m1;

  logic                         st_we;
  logic [AW-1:0]                st_waddr, st_raddr;
  logic [lxb_pkg::CHAR_W-1:0]   st_wdata, st_rdata;
  logic                         h_we;
  logic [HBW-1:0]               h_addr;
  logic [COUNT_WIDTH-1:0]       h_wdata, h_rdata, h_cur;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_EXEC);
  assign wi_m1  = wi_q - PW'(1);
  assign h_addr = ch_q[HBW-1:0];
  assign h_cur  = hvalid_q[h_addr] ? h_rdata : '0;

  always_comb begin
    unique case (lxb_pkg::op_e'(operation_i))
      lxb_pkg::OP_READAT: st_raddr = AW'(position_i);
      lxb_pkg::OP_ADD:    st_raddr = wi_m1[AW-1:0];
      default:            st_raddr = rd_q[AW-1:0];
    endcase
  end

  lxb_ram #(.WIDTH(lxb_pkg::CHAR_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  lxb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HIST_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_addr),
    .wdata_i (h_wdata),
    .raddr_i (char_in_i[HBW-1:0]),
    .rdata_o (h_rdata)
  );

  always_comb begin
    logic          full_now;
    logic          add_go;
    logic          grow_try;
    logic [GW-1:0] grown;
    logic [PW-1:0] cap_new;
    logic [GW-1:0] init_g;

    full_now = (wi_q >= cap_q);
    add_go   = 1'b0;
    grow_try = 1'b0;
    grown    = '0;
    cap_new  = cap_q;
    init_g   = GW'(cfg_i.init_cap);

    state_d  = state_q;
    wi_d     = wi_q;
    rd_d     = rd_q;
    mark_d   = mark_q;
    cap_d    = cap_q;
    empty_d  = empty_q;
    full_d   = full_q;
    grown_d  = grown_q;
    sum_d    = sum_q;
    ok_d     = 1'b0;
    cout_d   = '0;
    hcnt_d   = '0;
    st_we    = 1'b0;
    st_waddr = wi_q[AW-1:0];
    st_wdata = ch_q;
    h_we     = 1'b0;
    h_wdata  = h_cur + COUNT_WIDTH'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (op_q)
          lxb_pkg::OP_ADD: begin
            if (!full_now) begin
              add_go = 1'b1;
            end else begin
              unique case (cfg_i.growth_mode)
                lxb_pkg::GM_FIXED: begin
                  full_d = 1'b1;
                  if (wi_q != '0) begin
                    sum_d    = sum_q - st_rdata + cfg_i.term;
                    st_we    = 1'b1;
                    st_waddr = wi_m1[AW-1:0];
                    st_wdata = cfg_i.term;
                  end
                end
                lxb_pkg::GM_ADD: begin
                  grow_try = 1'b1;
                  grown    = GW'(cap_q) + GW'(cfg_i.growth_step);
                end
                lxb_pkg::GM_MUL: begin
                  grow_try = 1'b1;
                  grown    = GW'(cap_q) * GW'(cfg_i.growth_step);
                end
                default: begin
                end
              endcase
              if (grow_try && (grown > GW'(cap_q)) && (grown <= GW'(STORE_DEPTH))) begin
                cap_new = PW'(grown);
                cap_d   = cap_new;
                grown_d = 1'b1;
                add_go  = 1'b1;
              end
            end
            if (add_go && (wi_q < DEPTH_P)) begin
              st_we    = 1'b1;
              st_waddr = wi_q[AW-1:0];
              st_wdata = ch_q;
              wi_d     = wi_q + PW'(1);
              sum_d    = sum_q + ch_q;
              empty_d  = 1'b0;
              full_d   = ((wi_q + PW'(1)) == cap_new);
              ok_d     = 1'b1;
              if (({1'b0, ch_q} < 9'(HIST_BINS)) && (h_cur != CNT_MAX)) begin
                h_we = 1'b1;
              end
            end
          end
          lxb_pkg::OP_GET: begin
            if ((rd_q < wi_q) && (rd_q < DEPTH_P)) begin
              cout_d = st_rdata;
              rd_d   = rd_q + PW'(1);
              ok_d   = 1'b1;
            end else begin
              cout_d = cfg_i.term;
            end
          end
          lxb_pkg::OP_RETRACT: begin
            if (rd_q != '0) begin
              rd_d = rd_q - PW'(1);
              ok_d = 1'b1;
            end
          end
          lxb_pkg::OP_SETMARK: begin
            if (GW'(pos_q) < GW'(wi_q)) begin
              mark_d = pos_q;
              ok_d   = 1'b1;
            end
          end
          lxb_pkg::OP_RESTORE: begin
            if (GW'(mark_q) <= GW'(wi_q)) begin
              rd_d = PW'(mark_q);
              ok_d = 1'b1;
            end
          end
          lxb_pkg::OP_RECOVER: begin
            rd_d    = '0;
            mark_d  = '0;
            empty_d = (wi_q == '0);
            full_d  = 1'b0;
            ok_d    = 1'b1;
          end
          lxb_pkg::OP_CLEAR: begin
            wi_d    = '0;
            rd_d    = '0;
            mark_d  = '0;
            sum_d   = '0;
            empty_d = 1'b1;
            full_d  = 1'b0;
            grown_d = 1'b0;
            ok_d    = 1'b1;
            if (init_g == '0) begin
              cap_d = PW'(1);
            end else if (init_g > GW'(STORE_DEPTH)) begin
              cap_d = DEPTH_P;
            end else begin
              cap_d = PW'(cfg_i.init_cap);
            end
          end
          lxb_pkg::OP_READAT: begin
            if ((GW'(pos_q) < GW'(wi_q)) && (GW'(pos_q) < GW'(STORE_DEPTH))) begin
              cout_d = st_rdata;
              ok_d   = 1'b1;
            end else begin
              cout_d = cfg_i.term;
            end
          end
          lxb_pkg::OP_HIST: begin
            if ({1'b0, ch_q} < 9'(HIST_BINS)) begin
              hcnt_d = lxb_pkg::HCOUNT_W'(h_cur);
              ok_d   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= lxb_pkg::op_e'(operation_i);
      ch_q  <= char_in_i;
      pos_q <= position_i;
    end
    if (state_q == ST_EXEC) begin
      ok_q   <= ok_d;
      cout_q <= cout_d;
      hcnt_q <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      wi_q     <= '0;
      rd_q     <= '0;
      mark_q   <= '0;
      cap_q    <= CAP_RST;
      empty_q  <= 1'b1;
      full_q   <= 1'b0;
      grown_q  <= 1'b0;
      sum_q    <= '0;
      hvalid_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
      wi_q    <= wi_d;
      rd_q    <= rd_d;
      mark_q  <= mark_d;
      cap_q   <= cap_d;
      empty_q <= empty_d;
      full_q  <= full_d;
      grown_q <= grown_d;
      sum_q   <= sum_d;
      if (h_we) begin
        hvalid_q[h_addr] <= 1'b1;
      end
    end
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign char_out_o   = cout_q;
  assign hist_count_o = hcnt_q;
  assign write_pos_o  = lxb_pkg::CAP_W'(wi_q);
  assign read_pos_o   = lxb_pkg::CAP_W'(rd_q);
  assign mark_pos_o   = mark_q;
  assign capacity_o   = lxb_pkg::CAP_W'(cap_q);
  assign is_empty_o   = empty_q;
  assign is_full_o    = full_q;
  assign was_grown_o  = grown_q;
  assign byte_sum_o   = sum_q;

endmodule

// ----- hdl/lexer_input_buffer.sv -----
// Top level of the lexer input buffer with mark, pushback and histogram.
//
// A command beat is taken at a rising edge with start high and busy low.
// The block then reads the byte store and the histogram memory in the
// accept cycle, evaluates and writes back in the following cycle (busy is
// high there), and shows the result beat on the result ports for one cycle
// marked by done_o. A new command can be accepted in the cycle that shows
// the result, but not while busy is high. The read-modify-write through
// the registered memory read is why each command needs the busy cycle.
// The receiver cannot stall: a result beat is taken in the cycle it shows.
// Position, capacity, flag and sum ports show the state after the last
// command. Configuration is to be written through the APB port only while
// idle; the block itself does not enforce this. After reset the positions
// and the sum are zero, the buffer is empty, the capacity is the reset
// initial capacity and the histogram reads zero; no clearing pass runs and
// a command may be issued right away.
module lexer_input_buffer #(
  parameter int STORE_DEPTH = lxb_pkg::STORE_DEPTH_DEF,
  parameter int HIST_BINS   = lxb_pkg::HIST_BINS_DEF,
  parameter int COUNT_WIDTH = lxb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lxb_pkg::ADDR_W-1:0]    paddr,
  input  logic [lxb_pkg::DATA_W-1:0]    pwdata,
  output logic [lxb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [lxb_pkg::OP_W-1:0]      operation_i,
  input  logic [lxb_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [lxb_pkg::POS_W-1:0]     position_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [lxb_pkg::CHAR_W-1:0]    char_out_o,
  output logic [lxb_pkg::HCOUNT_W-1:0]  hist_count_o,
  output logic [lxb_pkg::CAP_W-1:0]     write_pos_o,
  output logic [lxb_pkg::CAP_W-1:0]     read_pos_o,
  output logic [lxb_pkg::POS_W-1:0]     mark_pos_o,
  output logic [lxb_pkg::CAP_W-1:0]     capacity_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          was_grown_o,
  output logic [lxb_pkg::CHAR_W-1:0]    byte_sum_o
);

  lxb_pkg::cfg_t cfg;

  lxb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lxb_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .HIST_BINS   (HIST_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .char_in_i    (char_in_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .char_out_o   (char_out_o),
    .hist_count_o (hist_count_o),
    .write_pos_o  (write_pos_o),
    .read_pos_o   (read_pos_o),
    .mark_pos_o   (mark_pos_o),
    .capacity_o   (capacity_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .was_grown_o  (was_grown_o),
    .byte_sum_o   (byte_sum_o)
  );

endmodule

// ----- hdl/lxb_checker.sv -----
// Port-level checker of the lexer input buffer and its bind statement.
`include "lexer_input_buffer_assert.svh"

module lxb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic                          is_empty_o,
  input logic                          is_full_o
);

  `LXB_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o)
  `LXB_ASSERT_NEXT(a_busy_done, busy, !busy && done_o)
  `LXB_ASSERT_NOW(a_done_idle, done_o, !busy)
  `LXB_ASSERT_NOW(a_full_not_empty, done_o && is_full_o, !is_empty_o)

endmodule

bind lexer_input_buffer lxb_checker u_lxb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .is_empty_o (is_empty_o),
  .is_full_o  (is_full_o)
);

// ----- verif/tb_lexer_input_buffer.sv -----
// Self-checking testbench for the lexer input buffer: APB setup, command beats and status checks.
`timescale 1ns / 100ps

module tb_lexer_input_buffer;

  localparam int STALL_LIMIT = 1000;
  localparam logic [lxb_pkg::GM_W-1:0] GM_NONE = 2'd3;
  localparam logic [lxb_pkg::OP_W-1:0] OP_LAST_CODE =
    lxb_pkg::OP_W'((1 << lxb_pkg::OP_W) - 1);

  typedef struct {
    logic [lxb_pkg::OP_W-1:0]   op;
    logic [lxb_pkg::CHAR_W-1:0] ch;
    logic [lxb_pkg::POS_W-1:0]  pos;
  } command_t;

  typedef struct {
    logic                         ok;
    logic [lxb_pkg::CHAR_W-1:0]   char_out;
    logic [lxb_pkg::HCOUNT_W-1:0] hist_count;
    logic [lxb_pkg::CAP_W-1:0]    write_pos;
    logic [lxb_pkg::CAP_W-1:0]    read_pos;
    logic [lxb_pkg::POS_W-1:0]    mark_pos;
    logic [lxb_pkg::CAP_W-1:0]    capacity;
    logic                         is_empty;
    logic                         is_full;
    logic                         was_grown;
    logic [lxb_pkg::CHAR_W-1:0]   byte_sum;
  } buffer_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lxb_pkg::ADDR_W-1:0] paddr = '0;
  logic [lxb_pkg::DATA_W-1:0] pwdata = '0;
  logic [lxb_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [lxb_pkg::OP_W-1:0] operation_i = '0;
  logic [lxb_pkg::CHAR_W-1:0] char_in_i = '0;
  logic [lxb_pkg::POS_W-1:0] position_i = '0;
  logic done_o;
  logic ok_o;
  logic [lxb_pkg::CHAR_W-1:0] char_out_o;
  logic [lxb_pkg::HCOUNT_W-1:0] hist_count_o;
  logic [lxb_pkg::CAP_W-1:0] write_pos_o;
  logic [lxb_pkg::CAP_W-1:0] read_pos_o;
  logic [lxb_pkg::POS_W-1:0] mark_pos_o;
  logic [lxb_pkg::CAP_W-1:0] capacity_o;
  logic is_empty_o;
  logic is_full_o;
  logic was_grown_o;
  logic [lxb_pkg::CHAR_W-1:0] byte_sum_o;

  command_t command_backlog[$];
  buffer_status_t predicted_status[$];
  int error_count = 0;
  int idle_pct = 0;
  int gap_left = 0;
  int quiet_cycles = 0;

  logic [lxb_pkg::CAP_W-1:0] cfg_init_cap = lxb_pkg::CAP_W'(lxb_pkg::CAP_RESET);
  logic [lxb_pkg::CAP_W-1:0] cfg_step = lxb_pkg::CAP_W'(lxb_pkg::STEP_RESET);
  logic [lxb_pkg::GM_W-1:0] cfg_mode = lxb_pkg::GM_FIXED;
  logic [lxb_pkg::CHAR_W-1:0] cfg_term = '0;

  logic [lxb_pkg::CHAR_W-1:0] store_model [lxb_pkg::STORE_DEPTH_DEF];
  logic [lxb_pkg::HCOUNT_W-1:0] hist_model [lxb_pkg::HIST_BINS_DEF];
  int wr_idx;
  int rd_idx;
  int mark_idx;
  int cap_now;
  logic empty_now;
  logic full_now;
  logic grown_now;
  logic [lxb_pkg::CHAR_W-1:0] sum_now;

  lexer_input_buffer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .operation_i(operation_i),
    .char_in_i(char_in_i),
    .position_i(position_i),
    .done_o(done_o),
    .ok_o(ok_o),
    .char_out_o(char_out_o),
    .hist_count_o(hist_count_o),
    .write_pos_o(write_pos_o),
    .read_pos_o(read_pos_o),
    .mark_pos_o(mark_pos_o),
    .capacity_o(capacity_o),
    .is_empty_o(is_empty_o),
    .is_full_o(is_full_o),
    .was_grown_o(was_grown_o),
    .byte_sum_o(byte_sum_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void restart_positions();
    wr_idx = 0;
    rd_idx = 0;
    mark_idx = 0;
    sum_now = '0;
    if (cfg_init_cap == '0) begin
      cap_now = 1;
    end else if (int'(cfg_init_cap) > lxb_pkg::STORE_DEPTH_DEF) begin
      cap_now = lxb_pkg::STORE_DEPTH_DEF;
    end else begin
      cap_now = int'(cfg_init_cap);
    end
    empty_now = 1'b1;
    full_now = 1'b0;
    grown_now = 1'b0;
  endfunction

  function automatic buffer_status_t step_buffer(command_t c);
    buffer_status_t r;
    int grown;
    logic room;
    r = '{default: '0};
    case (c.op)
      lxb_pkg::OP_ADD: begin
        room = 1'b1;
        if (wr_idx >= cap_now) begin
          room = 1'b0;
          if (cfg_mode == lxb_pkg::GM_FIXED) begin
            full_now = 1'b1;
            if (wr_idx > 0) begin
              sum_now = sum_now - store_model[wr_idx-1] + cfg_term;
              store_model[wr_idx-1] = cfg_term;
            end
          end else if (cfg_mode == lxb_pkg::GM_ADD || cfg_mode == lxb_pkg::GM_MUL) begin
            if (cfg_mode == lxb_pkg::GM_ADD) begin
              grown = cap_now + int'(cfg_step);
            end else begin
              grown = cap_now * int'(cfg_step);
            end
            if (grown > cap_now && grown <= lxb_pkg::STORE_DEPTH_DEF) begin
              cap_now = grown;
              grown_now = 1'b1;
              room = 1'b1;
            end
          end
        end
        if (room) begin
          store_model[wr_idx] = c.ch;
          wr_idx++;
          sum_now = sum_now + c.ch;
          empty_now = 1'b0;
          full_now = (wr_idx == cap_now);
          if (int'(c.ch) < lxb_pkg::HIST_BINS_DEF && hist_model[c.ch] != '1) begin
            hist_model[c.ch]++;
          end
          r.ok = 1'b1;
        end
      end
      lxb_pkg::OP_GET: begin
        if (rd_idx < wr_idx) begin
          r.char_out = store_model[rd_idx];
          rd_idx++;
          r.ok = 1'b1;
        end else begin
          r.char_out = cfg_term;
        end
      end
      lxb_pkg::OP_RETRACT: begin
        if (rd_idx > 0) begin
          rd_idx--;
          r.ok = 1'b1;
        end
      end
      lxb_pkg::OP_SETMARK: begin
        if (int'(c.pos) < wr_idx) begin
          mark_idx = int'(c.pos);
          r.ok = 1'b1;
        end
      end
      lxb_pkg::OP_RESTORE: begin
        if (mark_idx <= wr_idx) begin
          rd_idx = mark_idx;
          r.ok = 1'b1;
        end
      end
      lxb_pkg::OP_RECOVER: begin
        rd_idx = 0;
        mark_idx = 0;
        empty_now = (wr_idx == 0);
        full_now = 1'b0;
        r.ok = 1'b1;
      end
      lxb_pkg::OP_CLEAR: begin
        restart_positions();
        r.ok = 1'b1;
      end
      lxb_pkg::OP_READAT: begin
        if (int'(c.pos) < wr_idx) begin
          r.char_out = store_model[c.pos];
          r.ok = 1'b1;
        end else begin
          r.char_out = cfg_term;
        end
      end
      lxb_pkg::OP_HIST: begin
        if (int'(c.ch) < lxb_pkg::HIST_BINS_DEF) begin
          r.hist_count = hist_model[c.ch];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.write_pos = lxb_pkg::CAP_W'(wr_idx);
    r.read_pos = lxb_pkg::CAP_W'(rd_idx);
    r.mark_pos = lxb_pkg::POS_W'(mark_idx);
    r.capacity = lxb_pkg::CAP_W'(cap_now);
    r.is_empty = empty_now;
    r.is_full = full_now;
    r.was_grown = grown_now;
    r.byte_sum = sum_now;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    command_t taken;
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        taken = command_backlog.pop_front();
        predicted_status.push_back(step_buffer(taken));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (command_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 7);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        operation_i <= command_backlog[0].op;
        char_in_i <= command_backlog[0].ch;
        position_i <= command_backlog[0].pos;
      end
    end
  end

  always @(posedge clk_i) begin
    buffer_status_t want;
    if (rst_ni && done_o) begin
      if (predicted_status.size() == 0) begin
        $error("result beat with no command outstanding");
        error_count++;
      end else begin
        want = predicted_status.pop_front();
        check_field("ok", 32'(want.ok), 32'(ok_o));
        check_field("char_out", 32'(want.char_out), 32'(char_out_o));
        check_field("hist_count", 32'(want.hist_count), 32'(hist_count_o));
        check_field("write_pos", 32'(want.write_pos), 32'(write_pos_o));
        check_field("read_pos", 32'(want.read_pos), 32'(read_pos_o));
        check_field("mark_pos", 32'(want.mark_pos), 32'(mark_pos_o));
        check_field("capacity", 32'(want.capacity), 32'(capacity_o));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty_o));
        check_field("is_full", 32'(want.is_full), 32'(is_full_o));
        check_field("was_grown", 32'(want.was_grown), 32'(was_grown_o));
        check_field("byte_sum", 32'(want.byte_sum), 32'(byte_sum_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_register(lxb_pkg::reg_idx_e idx, logic [lxb_pkg::DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lxb_pkg::REG_INIT_CAP: cfg_init_cap = value[lxb_pkg::CAP_W-1:0];
      lxb_pkg::REG_STEP:     cfg_step = value[lxb_pkg::CAP_W-1:0];
      lxb_pkg::REG_MODE:     cfg_mode = value[lxb_pkg::GM_W-1:0];
      lxb_pkg::REG_TERM:     cfg_term = value[lxb_pkg::CHAR_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (command_backlog.size() != 0 || start || predicted_status.size() != 0);
  endtask

  function automatic void queue_command(logic [lxb_pkg::OP_W-1:0] op,
                                        logic [lxb_pkg::CHAR_W-1:0] ch,
                                        logic [lxb_pkg::POS_W-1:0] pos);
    command_t c;
    c.op = op;
    c.ch = ch;
    c.pos = pos;
    command_backlog.push_back(c);
  endfunction

  function automatic void queue_random(int clear_pct, int add_pct, int pos_max);
    int r;
    logic [lxb_pkg::OP_W-1:0] op;
    logic [lxb_pkg::POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < clear_pct) begin
      op = lxb_pkg::OP_CLEAR;
    end else if (r < clear_pct + add_pct) begin
      op = lxb_pkg::OP_ADD;
    end else begin
      case ($urandom_range(0, 14))
        0, 1, 2: op = lxb_pkg::OP_GET;
        3, 4:    op = lxb_pkg::OP_RETRACT;
        5, 6:    op = lxb_pkg::OP_SETMARK;
        7, 8:    op = lxb_pkg::OP_RESTORE;
        9:       op = lxb_pkg::OP_RECOVER;
        10, 11:  op = lxb_pkg::OP_READAT;
        12, 13:  op = lxb_pkg::OP_HIST;
        default: op = lxb_pkg::OP_W'($urandom_range(int'(lxb_pkg::OP_HIST) + 1,
                                                    int'(OP_LAST_CODE)));
      endcase
    end
    pos = lxb_pkg::POS_W'($urandom_range(0, 1) ? $urandom_range(0, pos_max)
                                               : $urandom_range(0, 1023));
    queue_command(op, lxb_pkg::CHAR_W'($urandom_range(0, 255)), pos);
  endfunction

  task automatic run_phase(int init_cap, int step, logic [lxb_pkg::GM_W-1:0] mode, int term,
                           int n_items, int clear_pct, int add_pct, int pos_max, int idle);
    wait_quiet();
    repeat (3) @(posedge clk_i);
    write_register(lxb_pkg::REG_INIT_CAP, lxb_pkg::DATA_W'(init_cap));
    write_register(lxb_pkg::REG_STEP, lxb_pkg::DATA_W'(step));
    write_register(lxb_pkg::REG_MODE, lxb_pkg::DATA_W'(mode));
    write_register(lxb_pkg::REG_TERM, lxb_pkg::DATA_W'(term));
    @(negedge clk_i);
    idle_pct = idle;
    queue_command(lxb_pkg::OP_CLEAR, '0, '0);
    for (int i = 0; i < n_items; i++) begin
      queue_random(clear_pct, add_pct, pos_max);
    end
  endtask

  initial begin
    foreach (store_model[i]) store_model[i] = '0;
    foreach (hist_model[i]) hist_model[i] = '0;
    restart_positions();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    idle_pct = 20;
    queue_command(lxb_pkg::OP_GET, '0, '0);
    queue_command(lxb_pkg::OP_RETRACT, '0, '0);
    queue_command(lxb_pkg::OP_READAT, '0, '0);
    queue_command(lxb_pkg::OP_SETMARK, '0, '0);
    queue_command(lxb_pkg::OP_RESTORE, '0, '0);
    queue_command(lxb_pkg::OP_HIST, '0, '0);
    queue_command(lxb_pkg::OP_HIST, 8'hFF, '0);
    queue_command(lxb_pkg::OP_W'(lxb_pkg::OP_HIST + 1), 8'hFF, 10'h3FF);
    queue_command(OP_LAST_CODE, 8'h00, 10'h000);
    queue_command(lxb_pkg::OP_ADD, 8'h00, '0);
    queue_command(lxb_pkg::OP_ADD, 8'hFF, '0);
    queue_command(lxb_pkg::OP_ADD, 8'h7F, '0);
    queue_command(lxb_pkg::OP_SETMARK, '0, 10'd1);
    repeat (4) queue_command(lxb_pkg::OP_GET, '0, '0);
    queue_command(lxb_pkg::OP_RETRACT, '0, '0);
    queue_command(lxb_pkg::OP_RESTORE, '0, '0);
    queue_command(lxb_pkg::OP_READAT, '0, 10'd2);
    queue_command(lxb_pkg::OP_READAT, '0, 10'h3FF);
    queue_command(lxb_pkg::OP_HIST, 8'h7F, '0);
    queue_command(lxb_pkg::OP_RECOVER, '0, '0);

    run_phase(2, 1, lxb_pkg::GM_FIXED, 8'hFF, 0, 0, 0, 0, 20);
    queue_command(lxb_pkg::OP_ADD, 8'h41, '0);
    queue_command(lxb_pkg::OP_ADD, 8'h80, '0);
    queue_command(lxb_pkg::OP_ADD, 8'h01, '0);
    queue_command(lxb_pkg::OP_READAT, '0, 10'd1);
    queue_command(lxb_pkg::OP_HIST, 8'h41, '0);

    run_phase(2, 1, lxb_pkg::GM_FIXED, 8'hFF, 100, 4, 50, 3, 20);
    run_phase(1, 1, lxb_pkg::GM_ADD, 8'h5A, 120, 3, 55, 40, 15);
    run_phase(4, 2, lxb_pkg::GM_MUL, 8'h80, 120, 3, 60, 64, 0);
    run_phase(0, 2047, lxb_pkg::GM_ADD, 8'h00, 80, 4, 50, 3, 25);
    run_phase(0, 5, GM_NONE, 8'hAA, 60, 4, 50, 3, 15);
    run_phase(3, 0, lxb_pkg::GM_ADD, 8'h33, 50, 4, 50, 7, 15);
    run_phase(1, 1, lxb_pkg::GM_MUL, 8'hFE, 50, 4, 50, 3, 15);
    run_phase(64, 4, lxb_pkg::GM_MUL, 8'hC3, 1080, 0, 96, 1023, 10);
    run_phase(2047, 1024, lxb_pkg::GM_ADD, 8'hFF, 40, 0, 60, 1023, 15);
    run_phase(16, 16, lxb_pkg::GM_ADD, int'($urandom_range(0, 255)), 120, 3, 55, 32, 0);

    wait_quiet();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lxb_pkg.sv
hdl/lxb_ram.sv
hdl/lxb_regs.sv
hdl/lxb_core.sv
hdl/lexer_input_buffer.sv
hdl/lxb_checker.sv
verif/tb_lexer_input_buffer.sv
